[rtl/list_set_union_intersection_unit_assert.svh]
// Assertion macros used by the RTL of the set union/intersection unit.
`ifndef LIST_SET_UNION_INTERSECTION_UNIT_ASSERT_SVH
`define LIST_SET_UNION_INTERSECTION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define LSUI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list_set_union_intersection_unit: implication failed");
// Next-cycle implication.
`define LSUI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list_set_union_intersection_unit: next-cycle check failed");
`else
`define LSUI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSUI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/lsui_pkg.sv]
package lsui_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] value_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_U_WALK,
      ST_V_WALK,
      ST_FINISH
   } walk_state_type;

   localparam logic MODE_UNION     = 1'b0;
   localparam logic MODE_INTERSECT = 1'b1;

   localparam logic LIST_U = 1'b0;

   // Per-cycle control broadcast to every cell of the chain.
   typedef struct packed {
      logic u_shift;
      logic v_shift;
      logic clear;
   } cell_ctl_type;

   // Contents one cell hands to its neighbor.
   typedef struct packed {
      value_type u_val;
      logic      u_occ;
      value_type v_val;
      logic      v_occ;
      logic      v_seen;
   } cell_data_type;

endpackage

[rtl/lsui_cell.sv]
module lsui_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lsui_pkg::cell_ctl_type  ctl,
   input  lsui_pkg::cell_data_type prev,
   input  lsui_pkg::value_type     key,
   output lsui_pkg::cell_data_type cur,
   output logic                    hit_u,
   output logic                    hit_v,
   output logic                    hit_vs
);
   import lsui_pkg::*;

   value_type u_val_ff, u_val_in;
   value_type v_val_ff, v_val_in;
   logic      u_occ_ff, u_occ_in;
   logic      v_occ_ff, v_occ_in;
   logic      v_seen_ff, v_seen_in;

   always_comb begin
      u_val_in  = ctl.u_shift ? prev.u_val : u_val_ff;
      v_val_in  = ctl.v_shift ? prev.v_val : v_val_ff;
      u_occ_in  = ctl.u_shift ? prev.u_occ : (u_occ_ff & ~ctl.clear);
      v_occ_in  = ctl.v_shift ? prev.v_occ : (v_occ_ff & ~ctl.clear);
      v_seen_in = ctl.v_shift ? prev.v_seen : (v_seen_ff & ~ctl.clear);
   end

   always_ff @(posedge clock) begin
      u_val_ff <= u_val_in;
      v_val_ff <= v_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_occ_ff  <= 1'b0;
         v_occ_ff  <= 1'b0;
         v_seen_ff <= 1'b0;
      end else begin
         u_occ_ff  <= u_occ_in;
         v_occ_ff  <= v_occ_in;
         v_seen_ff <= v_seen_in;
      end
   end

   // match the broadcast key against both held entries
   assign hit_u  = u_occ_ff && (u_val_ff == key);
   assign hit_v  = v_occ_ff && (v_val_ff == key);
   assign hit_vs = hit_v && v_seen_ff;

   assign cur = '{u_val: u_val_ff, u_occ: u_occ_ff, v_val: v_val_ff,
                  v_occ: v_occ_ff, v_seen: v_seen_ff};

endmodule

[rtl/list_set_union_intersection_unit.sv]
// Loading: one item per cycle; req_stall stays low while no result run is in progress.
// Run: the final V item starts a walk over every U cell, then in union mode a walk over
// every V cell, then a closing step; each walk step waits while a result sits stalled.
// A hit is held until the next hit or the close and leaves through one output register.
// Reset (synchronous, active high) empties both lists, clears overflow and selects union.
`include "list_set_union_intersection_unit_assert.svh"

module list_set_union_intersection_unit #(
   parameter int MAX_ITEMS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   // input items
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_list_sel,
   input  lsui_pkg::value_type req_value,
   input  logic                req_has_value,
   input  logic                req_last,
   // result items
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lsui_pkg::value_type rsp_out_value,
   output logic                rsp_out_last,
   output logic                rsp_result_empty,
   output logic                rsp_overflow
);
   import lsui_pkg::*;

   localparam int STEP_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_ITEMS - 1);

   // Both lists live in one chain of cells. Loading shifts a new entry in at cell 0,
   // so the oldest entry sits furthest down the chain. During a walk the chain rotates
   // (tail back to cell 0); over one full rotation the tail shows the entries in
   // arrival order, and the tail value is broadcast as the key for every cell to compare.

   cell_data_type  cur_d  [MAX_ITEMS];
   cell_data_type  prev_d [MAX_ITEMS];
   cell_data_type  head_d;
   cell_data_type  tail_d;
   cell_ctl_type   ctl;
   value_type      key;

   logic [MAX_ITEMS-1:0] hit_u_vec, hit_v_vec, hit_vs_vec;
   logic [MAX_ITEMS-1:0] u_occ_vec, v_occ_vec, v_seen_vec;

   walk_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              mode_ff, mode_in;
   logic              u_complete_ff, u_complete_in;
   logic              dropped_ff, dropped_in;
   logic              pend_valid_ff, pend_valid_in;
   value_type         pend_value_ff, pend_value_in;

   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff;
   logic              rsp_last_ff, rsp_empty_ff, rsp_ovf_ff;

   logic              req_accept;
   logic              out_free;
   logic              restart;
   logic              found;
   logic              push;
   value_type         push_value;
   logic              push_last;
   logic              push_empty;

   //------------------------------------------------------------------
   // Cell chain
   //------------------------------------------------------------------
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      lsui_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .prev   (prev_d[i]),
         .key    (key),
         .cur    (cur_d[i]),
         .hit_u  (hit_u_vec[i]),
         .hit_v  (hit_v_vec[i]),
         .hit_vs (hit_vs_vec[i])
      );
   end

   // Neighbor links; a clear that comes with a shift drops everything already held,
   // so only the head entry survives.
   always_comb begin
      prev_d[0] = head_d;
      for (int i = 1; i < MAX_ITEMS; i++) begin
         prev_d[i]       = cur_d[i-1];
         prev_d[i].u_occ = cur_d[i-1].u_occ & ~ctl.clear;
         prev_d[i].v_occ = cur_d[i-1].v_occ & ~ctl.clear;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         u_occ_vec[i]  = cur_d[i].u_occ;
         v_occ_vec[i]  = cur_d[i].v_occ;
         v_seen_vec[i] = cur_d[i].v_seen;
      end
   end

   assign tail_d = cur_d[MAX_ITEMS-1];
   assign key    = (state_ff == ST_V_WALK) ? tail_d.v_val : tail_d.u_val;

   //------------------------------------------------------------------
   // Handshake
   //------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign mode_in = csr_write_en ? csr_write_data : mode_ff;

   //------------------------------------------------------------------
   // Sequencer: loading, walks and run close
   //------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      u_complete_in = u_complete_ff;
      dropped_in    = dropped_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      ctl           = '0;
      restart       = 1'b0;
      found         = 1'b0;
      push          = 1'b0;
      push_value    = pend_value_ff;
      push_last     = 1'b0;
      push_empty    = 1'b0;
      // loading presents the incoming item at the head
      head_d = '{u_val: req_value, u_occ: 1'b1, v_val: req_value, v_occ: 1'b1,
                 v_seen: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_list_sel == LIST_U) begin
                  // a U item after a finished U list opens a new pair
                  restart   = u_complete_ff;
                  ctl.clear = restart;
                  if (restart) begin
                     dropped_in = 1'b0;
                  end
                  if (req_has_value) begin
                     if (restart || !u_occ_vec[MAX_ITEMS-1]) begin
                        ctl.u_shift = 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  u_complete_in = req_last | (u_complete_ff & ~restart);
               end else if (u_complete_ff) begin
                  if (req_has_value) begin
                     if (!v_occ_vec[MAX_ITEMS-1]) begin
                        ctl.v_shift = 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  if (req_last) begin
                     state_in = ST_U_WALK;
                  end
               end
            end
         end

         ST_U_WALK: begin
            if (out_free) begin
               ctl.u_shift = 1'b1;
               head_d      = tail_d;
               found       = tail_d.u_occ &&
                             ((mode_ff == MODE_UNION) ||
                              ((mode_ff == MODE_INTERSECT) && (|hit_v_vec)));
               if (found) begin
                  // hold the newest hit back until we know whether it closes the run
                  pend_valid_in = 1'b1;
                  pend_value_in = key;
                  push          = pend_valid_ff;
               end
               if (step_ff == STEP_LAST) begin
                  step_in  = '0;
                  state_in = (mode_ff == MODE_UNION) ? ST_V_WALK : ST_FINISH;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         ST_V_WALK: begin
            if (out_free) begin
               ctl.v_shift   = 1'b1;
               head_d        = tail_d;
               head_d.v_seen = 1'b1;   // mark the entry just examined as earlier
               found         = tail_d.v_occ && !(|hit_u_vec) && !(|hit_vs_vec);
               if (found) begin
                  pend_valid_in = 1'b1;
                  pend_value_in = key;
                  push          = pend_valid_ff;
               end
               if (step_ff == STEP_LAST) begin
                  step_in  = '0;
                  state_in = ST_FINISH;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               // close the run: the held hit goes out last, or an empty marker
               push          = 1'b1;
               push_last     = 1'b1;
               push_empty    = !pend_valid_ff;
               push_value    = pend_valid_ff ? pend_value_ff : '0;
               pend_valid_in = 1'b0;
               ctl.clear     = 1'b1;
               u_complete_in = 1'b0;
               dropped_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         mode_ff       <= MODE_UNION;
         u_complete_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         mode_ff       <= mode_in;
         u_complete_ff <= u_complete_in;
         dropped_ff    <= dropped_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
   end

   //------------------------------------------------------------------
   // Output register: a transfer frees it; a stalled result holds
   //------------------------------------------------------------------
   assign rsp_valid_in = push | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_value_ff <= push_value;
         rsp_last_ff  <= push_last;
         rsp_empty_ff <= push_empty;
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_result_empty = rsp_empty_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   //------------------------------------------------------------------
   // Checks
   //------------------------------------------------------------------
   `LSUI_ASSERT_IMPL(a_u_packed_idle, clock, reset, (state_ff == ST_IDLE), ((u_occ_vec & (u_occ_vec + 1'b1)) == '0))
   `LSUI_ASSERT_IMPL(a_v_packed_idle, clock, reset, (state_ff == ST_IDLE), ((v_occ_vec & (v_occ_vec + 1'b1)) == '0))
   `LSUI_ASSERT_IMPL(a_seen_clear_idle, clock, reset, (state_ff == ST_IDLE), (v_seen_vec == '0 && !pend_valid_ff))
   `LSUI_ASSERT_IMPL(a_step_rest, clock, reset, (state_ff == ST_IDLE || state_ff == ST_FINISH), (step_ff == '0))
   `LSUI_ASSERT_NEXT(a_close_last, clock, reset, (state_ff == ST_FINISH && out_free), (rsp_valid && rsp_out_last && state_ff == ST_IDLE))

endmodule

[dv/list_set_union_intersection_unit_checker.sv]
module list_set_union_intersection_unit_checker #(
   parameter int MAX_ITEMS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_list_sel,
   input  lsui_pkg::value_type req_value,
   input  logic                req_has_value,
   input  logic                req_last,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  lsui_pkg::value_type rsp_out_value,
   input  logic                rsp_out_last,
   input  logic                rsp_result_empty,
   input  logic                rsp_overflow,
   output int                  mismatches,
   output int                  awaited
);
   import lsui_pkg::*;

   typedef struct {
      value_type value;
      logic      last;
      logic      empty;
      logic      overflow;
   } set_result_type;

   set_result_type set_result_q[$];
   value_type      u_mem [MAX_ITEMS];
   value_type      v_mem [MAX_ITEMS];
   int             u_len;
   int             v_len;
   logic           u_done;
   logic           dropped;
   logic           mode;
   int             errs;

   function automatic bit found_in(input bit in_v, input value_type x, input int n);
      int i;
      for (i = 0; i < n; i++)
         if ((in_v ? v_mem[i] : u_mem[i]) == x) return 1'b1;
      return 1'b0;
   endfunction

   task automatic clear_pair();
      u_len   = 0;
      v_len   = 0;
      u_done  = 1'b0;
      dropped = 1'b0;
   endtask

   task automatic push_set_result(input value_type x, input logic empty);
      set_result_type r;
      r.value    = x;
      r.last     = 1'b0;
      r.empty    = empty;
      r.overflow = dropped;
      set_result_q.push_back(r);
   endtask

   // Build the whole result run of one U/V pair.
   task automatic form_set_run();
      int i;
      int start;
      start = set_result_q.size();
      if (mode == MODE_UNION) begin
         for (i = 0; i < u_len; i++) push_set_result(u_mem[i], 1'b0);
         for (i = 0; i < v_len; i++)
            if (!found_in(1'b0, v_mem[i], u_len) && !found_in(1'b1, v_mem[i], i))
               push_set_result(v_mem[i], 1'b0);
      end else begin
         for (i = 0; i < u_len; i++)
            if (found_in(1'b1, u_mem[i], v_len)) push_set_result(u_mem[i], 1'b0);
      end
      if (set_result_q.size() == start) push_set_result('0, 1'b1);
      set_result_q[set_result_q.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      set_result_type want;
      if (reset) begin
         set_result_q.delete();
         clear_pair();
         mode = MODE_UNION;
      end else begin
         if (csr_write_en) mode = csr_write_data;

         if (rsp_valid && !rsp_stall) begin
            if (set_result_q.size() == 0) begin
               $error("unexpected result: out_value %0d out_last %0b", rsp_out_value,
                      rsp_out_last);
               errs++;
            end else begin
               want = set_result_q.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %0d, actual %0d", want.value, rsp_out_value);
                  errs++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last: expected %0b, actual %0b", want.last, rsp_out_last);
                  errs++;
               end
               if (rsp_result_empty !== want.empty) begin
                  $error("result_empty: expected %0b, actual %0b", want.empty,
                         rsp_result_empty);
                  errs++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow, rsp_overflow);
                  errs++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_list_sel == LIST_U) begin
               if (u_done) clear_pair();
               if (req_has_value) begin
                  if (u_len < MAX_ITEMS) begin
                     u_mem[u_len] = req_value;
                     u_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               if (req_last) u_done = 1'b1;
            end else if (u_done) begin
               if (req_has_value) begin
                  if (v_len < MAX_ITEMS) begin
                     v_mem[v_len] = req_value;
                     v_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               if (req_last) begin
                  form_set_run();
                  clear_pair();
               end
            end
         end
      end
      mismatches <= errs;
      awaited    <= set_result_q.size();
   end

endmodule

[dv/list_set_union_intersection_unit_tb.sv]
module list_set_union_intersection_unit_tb;
   import lsui_pkg::*;

   localparam int   MAX_ITEMS     = 32;
   localparam logic LIST_V        = ~LIST_U;
   // a run walks U, in union mode also V, and then closes; leave margin on top
   localparam int   SETTLE_CYCLES = 2 * MAX_ITEMS + 8;
   localparam int   TARGET_ITEMS  = 370;
   localparam int   LONG_HOLD     = 400;

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      csr_write_en   = 1'b0;
   logic      csr_write_data = MODE_UNION;
   logic      req_valid      = 1'b0;
   logic      req_list_sel   = LIST_U;
   value_type req_value      = '0;
   logic      req_has_value  = 1'b0;
   logic      req_last       = 1'b0;
   logic      rsp_stall      = 1'b0;
   logic      req_stall;
   logic      rsp_valid;
   value_type rsp_out_value;
   logic      rsp_out_last;
   logic      rsp_result_empty;
   logic      rsp_overflow;
   int        mismatches;
   int        awaited;

   bit        steady;       // set: neither side adds random gaps
   int        items_sent;
   value_type list_buf[$];
   value_type pool[6];

   always #6 clock = ~clock;

   list_set_union_intersection_unit #(.MAX_ITEMS(MAX_ITEMS)) dut (.*);

   list_set_union_intersection_unit_checker #(.MAX_ITEMS(MAX_ITEMS)) checker_i (.*);

   // Offer one item after a random gap and hold it until the transfer.
   task automatic offer(input logic sel, input value_type val, input logic has,
                        input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_list_sel  <= sel;
      req_value     <= val;
      req_has_value <= has;
      req_last      <= fin;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   // Send list_buf as one list. An empty list, or marker_end, closes the list
   // with an item that carries no element; blanks sprinkles element-less items.
   task automatic send_list(input logic sel, input bit marker_end, input bit blanks);
      int i;
      for (i = 0; i < list_buf.size(); i++) begin
         if (blanks && $urandom_range(0, 4) == 0)
            offer(sel, value_type'($urandom), 1'b0, 1'b0);
         offer(sel, list_buf[i], 1'b1, (i == list_buf.size() - 1) && !marker_end);
      end
      if (marker_end || list_buf.size() == 0)
         offer(sel, value_type'($urandom), 1'b0, 1'b1);
   endtask

   task automatic fill_list(input int len, input bit narrow);
      list_buf.delete();
      repeat (len)
         list_buf.push_back(narrow ? pool[$urandom_range(0, 5)] : value_type'($urandom));
   endtask

   // Mostly short lists; now and then one around the capacity edge.
   function automatic int pick_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(MAX_ITEMS - 3, MAX_ITEMS + 3);
      return $urandom_range(0, 6);
   endfunction

   task automatic send_pair(input int u_len, input int v_len);
      bit narrow;
      narrow = ($urandom_range(0, 3) != 0);
      fill_list(u_len, narrow);
      send_list(LIST_U, $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      fill_list(v_len, narrow);
      send_list(LIST_V, $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
   endtask

   // Drop valid, wait for the last expected result, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Result side: stall a random number of cycles before each transfer, and
   // twice hold off for a long stretch so the block backs up into its input.
   initial begin : drain
      int hold;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 7);
         if (taken == 40 || taken == 150) hold = LONG_HOLD;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   initial begin : stimulus
      int pairs;
      items_sent = 0;
      steady     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Union: both lists empty gives the lone empty marker.
      set_mode(MODE_UNION);
      list_buf.delete();
      send_list(LIST_U, 1'b0, 1'b0);
      send_list(LIST_V, 1'b0, 1'b0);
      // Union over the value extremes, with a repeated new V value.
      list_buf = '{32'sh8000_0000, 32'sh7fff_ffff, -1, 0};
      send_list(LIST_U, 1'b0, 1'b0);
      list_buf = '{0, 5, 5, 32'sh7fff_ffff};
      send_list(LIST_V, 1'b0, 1'b0);

      // Intersection.
      set_mode(MODE_INTERSECT);
      // V item before U is complete: ignored
      offer(LIST_V, 9, 1'b1, 1'b1);
      // duplicates in U kept, element-less item in the middle of U
      offer(LIST_U, 7, 1'b1, 1'b0);
      offer(LIST_U, 123, 1'b0, 1'b0);
      offer(LIST_U, 7, 1'b1, 1'b0);
      offer(LIST_U, -3, 1'b1, 1'b1);
      list_buf = '{7, 1};
      send_list(LIST_V, 1'b0, 1'b0);
      // a U item after U is complete starts a new pair
      list_buf = '{1, 2};
      send_list(LIST_U, 1'b0, 1'b0);
      list_buf = '{3};
      send_list(LIST_U, 1'b0, 1'b0);
      list_buf = '{3, 4};
      send_list(LIST_V, 1'b0, 1'b0);
      // nothing in common: empty marker
      offer(LIST_U, 1, 1'b1, 1'b1);
      offer(LIST_V, 2, 1'b1, 1'b1);

      pool[0] = 32'sh8000_0000;
      pool[1] = 32'sh7fff_ffff;
      pool[2] = '0;
      pool[3] = value_type'($urandom);
      pool[4] = value_type'($urandom);
      pool[5] = value_type'($urandom);

      // Both lists past capacity so elements are dropped and flagged.
      set_mode(MODE_UNION);
      send_pair(MAX_ITEMS + 2, MAX_ITEMS + 1);

      while (items_sent < TARGET_ITEMS) begin
         set_mode(($urandom_range(0, 1) != 0) ? MODE_INTERSECT : MODE_UNION);
         steady = ($urandom_range(0, 3) == 0);
         pairs  = $urandom_range(1, 4);
         repeat (pairs) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: stray and broken items
               repeat ($urandom_range(1, 4))
                  offer(logic'($urandom), value_type'($urandom), logic'($urandom),
                        logic'($urandom));
            end else begin
               send_pair(pick_len(), pick_len());
            end
         end
      end
      steady = 1'b0;

      wait_idle();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/lsui_pkg.sv
rtl/lsui_cell.sv
rtl/list_set_union_intersection_unit.sv
dv/list_set_union_intersection_unit_checker.sv
dv/list_set_union_intersection_unit_tb.sv
